// ===== sv/crshc_pkg.sv =====
// shared types and constants for the cd raw sector header checker
package crshc_pkg;

   localparam int LBA_W   = 19;
   localparam int SECS_W  = 13;
   localparam int MIN_W   = 7;
   localparam int FRM_W   = 7;
   localparam int SEC_W   = 6;
   localparam int BCD_W   = 8;
   localparam int POS_W   = 4;
   localparam int CNT_W   = 4;

   // register indexes on the csr port
   localparam logic CSR_SECTOR_LBA = 1'b0;
   localparam logic CSR_MSF_SLOPPY = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
   localparam logic [1:0] VERDICT_ALL_ZERO  = 2'd1;
   localparam logic [1:0] VERDICT_NO_SYNC   = 2'd2;
   localparam logic [1:0] VERDICT_WRONG_MSF = 2'd3;

   // sector layout
   localparam int SYNC_LEN = 12;
   localparam logic [POS_W-1:0] POS_SYNC_END = 4'd12;
   localparam logic [POS_W-1:0] POS_MINUTE   = 4'd12;
   localparam logic [POS_W-1:0] POS_SECOND   = 4'd13;
   localparam logic [POS_W-1:0] POS_FRAME    = 4'd14;
   localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
   localparam logic [CNT_W-1:0] SYNC_MIN_MATCHES = 4'd8;

   localparam logic [BCD_W-1:0] SYNC_REF [SYNC_LEN] = '{
      8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00
   };

   // address arithmetic: lba + 150 frames, 75 frames/s, 60 s/min
   localparam logic [LBA_W-1:0]  FRAMES_PER_SECOND  = 19'd75;
   localparam logic [SECS_W-1:0] LEAD_IN_SECONDS    = 13'd2;
   localparam logic [MIN_W-1:0]  SECONDS_PER_MINUTE = 7'd60;
   // reciprocals: exact floor for lba < 2**19 and seconds < 2**13
   localparam logic [LBA_W-1:0]  DIV75_MUL   = 19'd447393;
   localparam int                DIV75_SHIFT = 25;
   localparam logic [13:0]       DIV60_MUL   = 14'd8739;
   localparam int                DIV60_SHIFT = 19;

   // cycles the address pipeline needs to settle after a new lba
   localparam logic [2:0] MSF_SETTLE = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [3:0] sync_matches;
   } rsp_payload_type;

   typedef struct packed {
      logic [BCD_W-1:0] minute;
      logic [BCD_W-1:0] second;
      logic [BCD_W-1:0] frame;
   } msf_bcd_type;

   // binary to bcd for values below 128, tens digit may exceed nine
   function automatic logic [BCD_W-1:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {8'd0, v} * 15'd205;
      tens = prod[14:11];
      ones = v - 7'({3'd0, tens} * 7'd10);
      return {tens, ones[3:0]};
   endfunction

endpackage

// ===== sv/crshc_msf.sv =====
// sector lba register and pipelined conversion to expected bcd msf header bytes
module crshc_msf import crshc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                lba_wr_en,
   input  logic [LBA_W-1:0]    lba_wdata,
   output msf_bcd_type         exp_msf,
   output logic                busy
);

   logic [LBA_W-1:0]  lba_ff;
   logic [SECS_W-1:0] quot_ff;
   logic [FRM_W-1:0]  frm_ff;
   logic [SECS_W-1:0] secs_ff;
   logic [MIN_W-1:0]  min_ff;
   msf_bcd_type       exp_ff;
   logic [2:0]        settle_ff;

   logic [2*LBA_W-1:0] quot_prod;
   logic [LBA_W-1:0]   frm_full;
   logic [26:0]        min_prod;
   logic [SECS_W-1:0]  sec_full;
   logic [SECS_W-1:0]  quot_in;
   logic [FRM_W-1:0]   frm_in;
   logic [SECS_W-1:0]  secs_in;
   logic [MIN_W-1:0]   min_in;
   msf_bcd_type        exp_in;
   logic [2:0]         settle_in;

   always_comb begin
      // stage 1: frames / 75 by reciprocal
      quot_prod = {{LBA_W{1'b0}}, lba_ff} * {{LBA_W{1'b0}}, DIV75_MUL};
      quot_in   = quot_prod[DIV75_SHIFT +: SECS_W];
      // stage 2: frame remainder and seconds with lead-in
      frm_full  = lba_ff - LBA_W'({{(LBA_W-SECS_W){1'b0}}, quot_ff} * FRAMES_PER_SECOND);
      frm_in    = frm_full[FRM_W-1:0];
      secs_in   = quot_ff + LEAD_IN_SECONDS;
      // stage 3: seconds / 60 by reciprocal
      min_prod  = {14'd0, secs_ff} * {13'd0, DIV60_MUL};
      min_in    = min_prod[DIV60_SHIFT +: MIN_W];
      // stage 4: second remainder and bcd
      sec_full  = secs_ff - SECS_W'({6'd0, min_ff} * {6'd0, SECONDS_PER_MINUTE});
      exp_in.minute = to_bcd(min_ff);
      exp_in.second = to_bcd({1'b0, sec_full[SEC_W-1:0]});
      exp_in.frame  = to_bcd(frm_ff);
      if (lba_wr_en) begin
         settle_in = MSF_SETTLE;
      end else if (settle_ff != 3'd0) begin
         settle_in = settle_ff - 3'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lba_ff    <= '0;
         settle_ff <= MSF_SETTLE;
      end else begin
         if (lba_wr_en) begin
            lba_ff <= lba_wdata;
         end
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      frm_ff  <= frm_in;
      secs_ff <= secs_in;
      min_ff  <= min_in;
      exp_ff  <= exp_in;
   end

   assign exp_msf = exp_ff;
   assign busy    = (settle_ff != 3'd0);

endmodule

// ===== sv/crshc_check.sv =====
// byte register, per-sector check state and verdict register
module crshc_check import crshc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall,
   input  msf_bcd_type     exp_msf,
   input  logic            msf_sloppy,
   input  logic            msf_busy
);

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [POS_W-1:0] pos_ff;
   logic [CNT_W-1:0] sync_cnt_ff;
   logic             zero_ff;
   logic             min_ok_ff;
   logic             sec_ok_ff;
   logic             frm_ok_ff;

   logic [POS_W-1:0] pos_in;
   logic [CNT_W-1:0] sync_cnt_in;
   logic             zero_in;
   logic             min_ok_in;
   logic             sec_ok_in;
   logic             frm_ok_in;
   logic [1:0]       verdict_in;
   logic [BCD_W-1:0] ref_byte;
   logic             sync_hit;
   logic             proc_ok;
   logic             advance;
   logic             process;
   logic             finish;
   logic             accept;

   always_comb begin
      // a last byte waits only while the verdict register is still held
      proc_ok   = !in_data_ff.last_byte || !(rsp_valid_ff && rsp_stall);
      advance   = !in_valid_ff || proc_ok;
      req_stall = msf_busy || !advance;
      accept    = req_valid && !req_stall;
      process   = in_valid_ff && proc_ok;
      finish    = process && in_data_ff.last_byte;

      ref_byte    = (pos_ff < POS_SYNC_END) ? SYNC_REF[pos_ff] : 8'h00;
      sync_hit    = (pos_ff < POS_SYNC_END) && (in_data_ff.data_byte == ref_byte);
      sync_cnt_in = sync_cnt_ff + {{(CNT_W-1){1'b0}}, sync_hit};
      zero_in     = zero_ff && (in_data_ff.data_byte == 8'h00);
      min_ok_in   = (pos_ff == POS_MINUTE) ? (in_data_ff.data_byte == exp_msf.minute)
                                           : min_ok_ff;
      sec_ok_in   = (pos_ff == POS_SECOND) ? (in_data_ff.data_byte == exp_msf.second)
                                           : sec_ok_ff;
      frm_ok_in   = (pos_ff == POS_FRAME) ? (in_data_ff.data_byte == exp_msf.frame)
                                          : frm_ok_ff;
      pos_in      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 4'd1;

      priority if (zero_in) begin
         verdict_in = VERDICT_ALL_ZERO;
      end else if (sync_cnt_in < SYNC_MIN_MATCHES) begin
         verdict_in = VERDICT_NO_SYNC;
      end else if (msf_sloppy && frm_ok_in) begin
         verdict_in = VERDICT_ACCEPTED;
      end else if (min_ok_in && sec_ok_in && frm_ok_in) begin
         verdict_in = VERDICT_ACCEPTED;
      end else begin
         verdict_in = VERDICT_WRONG_MSF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sync_cnt_ff  <= '0;
         zero_ff      <= 1'b1;
         min_ok_ff    <= 1'b0;
         sec_ok_ff    <= 1'b0;
         frm_ok_ff    <= 1'b0;
      end else begin
         if (advance) begin
            in_valid_ff <= accept;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // the sector state starts over after every verdict
         if (finish) begin
            pos_ff      <= '0;
            sync_cnt_ff <= '0;
            zero_ff     <= 1'b1;
            min_ok_ff   <= 1'b0;
            sec_ok_ff   <= 1'b0;
            frm_ok_ff   <= 1'b0;
         end else if (process) begin
            pos_ff      <= pos_in;
            sync_cnt_ff <= sync_cnt_in;
            zero_ff     <= zero_in;
            min_ok_ff   <= min_ok_in;
            sec_ok_ff   <= sec_ok_in;
            frm_ok_ff   <= frm_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
      if (finish) begin
         rsp_data_ff.verdict      <= verdict_in;
         rsp_data_ff.sync_matches <= sync_cnt_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== sv/cd_raw_sector_header_check_top.sv =====
// Raw CD sector checker: takes one sector byte per cycle and, on the byte marked last, returns
// one verdict (accepted, all zero, sync missing or wrong MSF header) with the sync match count.
// Bytes flow back to back at one per clock unless stalled; the verdict is registered from the
// last byte held in the input register, where a last byte waits only while the previous verdict
// is still stalled on the result side. The expected header bytes come from a four-stage pipeline
// (two reciprocal multiplies and a bcd split) fed by sector_lba, so req_stall is held after
// reset and after every sector_lba write until it settles; msf_sloppy takes effect at once.
module cd_raw_sector_header_check_top import crshc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall,
   input  logic            csr_wr_en,
   input  logic            csr_index,
   input  logic [LBA_W-1:0] csr_wdata
);

   logic        sloppy_ff;
   logic        lba_wr_en;
   msf_bcd_type exp_msf;
   logic        msf_busy;

   always_comb begin
      lba_wr_en = 1'b0;
      unique case (csr_index)
         CSR_SECTOR_LBA: lba_wr_en = csr_wr_en;
         CSR_MSF_SLOPPY: lba_wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sloppy_ff <= 1'b1;
      end else if (csr_wr_en && (csr_index == CSR_MSF_SLOPPY)) begin
         sloppy_ff <= csr_wdata[0];
      end
   end

   crshc_msf u_msf (
      .clock     (clock),
      .reset     (reset),
      .lba_wr_en (lba_wr_en),
      .lba_wdata (csr_wdata),
      .exp_msf   (exp_msf),
      .busy      (msf_busy)
   );

   crshc_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall),
      .exp_msf     (exp_msf),
      .msf_sloppy  (sloppy_ff),
      .msf_busy    (msf_busy)
   );

endmodule
